### src/stereo_multi_waveform_oscillator_core_assert.svh
// Assertion macros for the stereo oscillator core.
`ifndef STEREO_MULTI_WAVEFORM_OSCILLATOR_CORE_ASSERT_SVH
`define STEREO_MULTI_WAVEFORM_OSCILLATOR_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define SMWO_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define SMWO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/smwo_pkg.sv
// Shared types, constants, sine table and waveform function for the stereo oscillator.
package smwo_pkg;

  localparam int PHASE_BITS_DEF  = 32;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int QUARTER_SINE_DEPTH = 256;
  localparam int SINE_IDX_W         = $clog2(QUARTER_SINE_DEPTH + 1);

  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 3;
  localparam int WAVE_W      = 17;   // Q1.15 plus room for +1.0

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned TAYLOR_DIV [7] = '{6, 20, 42, 72, 110, 156, 210};

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LEFT_STEP  = 3'd0,
    REG_RIGHT_STEP = 3'd1,
    REG_WAVE_SHAPE = 3'd2,
    REG_PULSE_DUTY = 3'd3,
    REG_GAIN       = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    SHAPE_SINE     = 3'd0,
    SHAPE_TRIANGLE = 3'd1,
    SHAPE_SQUARE   = 3'd2,
    SHAPE_SAW      = 3'd3,
    SHAPE_PULSE    = 3'd4
  } shape_t;

  localparam logic [15:0] DUTY_RST = 16'd32768;
  localparam logic [15:0] GAIN_RST = 16'd32768;

  typedef logic [15:0] sine_tab_t [QUARTER_SINE_DEPTH + 1];

  // Q30 Taylor series for sin(pi/2 * k / depth), rounded to Q15 and clamped to 0..1.0
  function automatic logic [15:0] sine_q15(int unsigned k);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        rnd;
    x    = (HALF_PI_Q30 * 64'(k) + 64'(QUARTER_SINE_DEPTH / 2)) / QUARTER_SINE_DEPTH;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    for (int n = 0; n < 7; n++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[n];
      if (n % 2 == 0) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 64'sd0;
    end
    rnd = ($unsigned(sum) + 64'd16384) >> 15;
    if (rnd > 64'd32768) begin
      rnd = 64'd32768;
    end
    return 16'(rnd);
  endfunction

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t tab;
    for (int unsigned k = 0; k <= QUARTER_SINE_DEPTH; k++) begin
      tab[k] = sine_q15(k);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

  // Waveform value in Q1.15 (range -1.0..+1.0) from the top 16 phase bits
  function automatic logic signed [WAVE_W-1:0] wave_value(
    logic [15:0] u,
    logic [2:0]  shape,
    logic [15:0] duty
  );
    logic [14:0]               span;
    logic [31:0]               scaled;
    logic [SINE_IDX_W-1:0]     idx;
    logic signed [WAVE_W-1:0]  mag;
    logic signed [WAVE_W:0]    tri_x2;
    logic signed [WAVE_W:0]    tri_v;
    logic signed [WAVE_W-1:0]  w;
    // odd quadrants read the table mirrored
    span   = u[14] ? (15'd16384 - {1'b0, u[13:0]}) : {1'b0, u[13:0]};
    scaled = 32'(span) * 32'(QUARTER_SINE_DEPTH);
    idx    = SINE_IDX_W'(scaled >> 14);
    mag    = $signed({1'b0, SINE_TAB[idx]});
    tri_x2 = $signed({1'b0, u, 1'b0});
    tri_v  = u[15] ? (18'sd98304 - tri_x2) : (tri_x2 - 18'sd32768);
    unique case (shape_t'(shape))
      SHAPE_SINE:     w = u[15] ? -mag : mag;
      SHAPE_TRIANGLE: w = WAVE_W'(tri_v);
      SHAPE_SQUARE:   w = u[15] ? -17'sd32768 : 17'sd32768;
      SHAPE_SAW:      w = $signed({1'b0, u}) - 17'sd32768;
      SHAPE_PULSE:    w = (u < duty) ? 17'sd32768 : -17'sd32768;
      default:        w = '0;
    endcase
    return w;
  endfunction

endpackage

### src/stereo_multi_waveform_oscillator_core.sv
// Stereo multi-waveform DDS oscillator core: phase accumulators, waveform stage, output register.
//
// Each accepted input word is one sample tick and yields one stereo output word.
// The block takes one word per clock unless out_ready stalls the output; a
// tick passes the phase capture register, then waveform, gain and saturation
// into the output register. Both accumulators add their step on each accepted
// word. in_restart zeroes both phases before that tick's
// samples. Shapes: sine (quarter-wave table, no interpolation), triangle,
// square, saw, pulse against pulse_duty, silence for other codes. Samples are
// scaled by gain (Q1.15, 32768 is unity), rounded and saturated. Configuration
// registers should only be written while no tick is in flight.
`default_nettype none

module stereo_multi_waveform_oscillator_core #(
  parameter int PHASE_BITS  = smwo_pkg::PHASE_BITS_DEF,
  parameter int SAMPLE_BITS = smwo_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [smwo_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [smwo_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                in_restart,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [SAMPLE_BITS-1:0]            out_left_sample,
  output logic signed [SAMPLE_BITS-1:0]            out_right_sample
);

  localparam int PROD_W    = smwo_pkg::WAVE_W + 17;
  localparam int OUT_SHIFT = 31 - SAMPLE_BITS;
  localparam logic signed [PROD_W-1:0] RND_BIAS = PROD_W'(1) <<< (OUT_SHIFT - 1);
  localparam logic signed [PROD_W-1:0] SAT_MAX  = (PROD_W'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam logic signed [PROD_W-1:0] SAT_MIN  = -(PROD_W'(1) <<< (SAMPLE_BITS - 1));

  // configuration
  logic [smwo_pkg::CFG_DATA_W-1:0] left_step_r, left_step_nxt;
  logic [smwo_pkg::CFG_DATA_W-1:0] right_step_r, right_step_nxt;
  logic [2:0]                      wave_shape_r, wave_shape_nxt;
  logic [15:0]                     pulse_duty_r, pulse_duty_nxt;
  logic [15:0]                     gain_r, gain_nxt;

  // phase accumulators
  logic [PHASE_BITS-1:0] left_phase_r, left_phase_nxt;
  logic [PHASE_BITS-1:0] right_phase_r, right_phase_nxt;
  logic [PHASE_BITS-1:0] left_cur, right_cur;

  // capture stage
  logic        s1_valid_r, s1_valid_nxt;
  logic [15:0] s1_left_u_r, s1_left_u_nxt;
  logic [15:0] s1_right_u_r, s1_right_u_nxt;

  // output stage
  logic                          out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] out_left_r, out_left_nxt;
  logic signed [SAMPLE_BITS-1:0] out_right_r, out_right_nxt;

  logic in_acc;
  logic s1_adv;

  function automatic logic signed [SAMPLE_BITS-1:0] scale_sat(
    logic signed [smwo_pkg::WAVE_W-1:0] w,
    logic [15:0]                        g
  );
    logic signed [PROD_W-1:0] p;
    logic signed [PROD_W-1:0] v;
    p = PROD_W'(w) * $signed({{(PROD_W - 16){1'b0}}, g});
    v = (p + RND_BIAS) >>> OUT_SHIFT;
    if (v > SAT_MAX) begin
      v = SAT_MAX;
    end else if (v < SAT_MIN) begin
      v = SAT_MIN;
    end
    return SAMPLE_BITS'(v);
  endfunction

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    left_step_nxt  = left_step_r;
    right_step_nxt = right_step_r;
    wave_shape_nxt = wave_shape_r;
    pulse_duty_nxt = pulse_duty_r;
    gain_nxt       = gain_r;
    if (cfg_we) begin
      unique case (smwo_pkg::cfg_reg_t'(cfg_index))
        smwo_pkg::REG_LEFT_STEP:  left_step_nxt  = cfg_data;
        smwo_pkg::REG_RIGHT_STEP: right_step_nxt = cfg_data;
        smwo_pkg::REG_WAVE_SHAPE: wave_shape_nxt = cfg_data[2:0];
        smwo_pkg::REG_PULSE_DUTY: pulse_duty_nxt = cfg_data[15:0];
        smwo_pkg::REG_GAIN:       gain_nxt       = cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    left_cur        = in_restart ? '0 : left_phase_r;
    right_cur       = in_restart ? '0 : right_phase_r;
    left_phase_nxt  = left_phase_r;
    right_phase_nxt = right_phase_r;
    s1_left_u_nxt   = s1_left_u_r;
    s1_right_u_nxt  = s1_right_u_r;
    s1_valid_nxt    = s1_adv ? 1'b0 : s1_valid_r;
    if (in_acc) begin
      left_phase_nxt  = left_cur + PHASE_BITS'(left_step_r);
      right_phase_nxt = right_cur + PHASE_BITS'(right_step_r);
      s1_left_u_nxt   = left_cur[PHASE_BITS-1 -: 16];
      s1_right_u_nxt  = right_cur[PHASE_BITS-1 -: 16];
      s1_valid_nxt    = 1'b1;
    end
  end

  always_comb begin
    out_left_nxt  = out_left_r;
    out_right_nxt = out_right_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    if (s1_adv) begin
      out_left_nxt  = scale_sat(
        smwo_pkg::wave_value(s1_left_u_r, wave_shape_r, pulse_duty_r), gain_r);
      out_right_nxt = scale_sat(
        smwo_pkg::wave_value(s1_right_u_r, wave_shape_r, pulse_duty_r), gain_r);
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_step_r   <= '0;
      right_step_r  <= '0;
      wave_shape_r  <= smwo_pkg::SHAPE_SINE;
      pulse_duty_r  <= smwo_pkg::DUTY_RST;
      gain_r        <= smwo_pkg::GAIN_RST;
      left_phase_r  <= '0;
      right_phase_r <= '0;
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      left_step_r   <= left_step_nxt;
      right_step_r  <= right_step_nxt;
      wave_shape_r  <= wave_shape_nxt;
      pulse_duty_r  <= pulse_duty_nxt;
      gain_r        <= gain_nxt;
      left_phase_r  <= left_phase_nxt;
      right_phase_r <= right_phase_nxt;
      s1_valid_r    <= s1_valid_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_left_u_r  <= s1_left_u_nxt;
    s1_right_u_r <= s1_right_u_nxt;
    out_left_r   <= out_left_nxt;
    out_right_r  <= out_right_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_left_sample  = out_left_r;
  assign out_right_sample = out_right_r;

`include "stereo_multi_waveform_oscillator_core_assert.svh"

  // a restart tick samples both channels at phase zero
  `SMWO_ASSERT_NEXT(a_restart_zero, clk, rst_n, in_acc && in_restart, s1_left_u_r == '0 && s1_right_u_r == '0, "restart did not clear phases")
  // a captured word is never dropped while the output side stalls
  `SMWO_ASSERT_NEXT(a_s1_hold, clk, rst_n, s1_valid_r && !s1_adv, s1_valid_r && $stable(s1_left_u_r) && $stable(s1_right_u_r), "capture stage lost a word")
  // no new word is taken while the capture stage is blocked
  `SMWO_ASSERT_NOW(a_no_overrun, clk, rst_n, s1_valid_r && !s1_adv, !in_ready, "input accepted into a full stage")
  // undefined shape codes give silence
  `SMWO_ASSERT_NEXT(a_silence, clk, rst_n, s1_adv && wave_shape_r > smwo_pkg::SHAPE_PULSE, out_left_r == '0 && out_right_r == '0, "undefined shape not silent")

endmodule

`default_nettype wire
